@@ rtl/trrm_pkg.sv @@
// Package for the tile region range map: item types, op codes, table entry types.
// No dependencies.
package trrm_pkg;

    localparam int unsigned REGION_DEPTH_DEF  = 128;
    localparam int unsigned STAGING_DEPTH_DEF = 8;
    localparam logic [7:0]  UNMAPPED_SHEET    = 8'hFF;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_REGISTER = 3'd1,
        OP_RECORD   = 3'd2,
        OP_COPY     = 3'd3,
        OP_RESOLVE  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]         operation;
        logic [15:0]        vram_addr;
        logic [7:0]         sheet;
        logic [15:0]        tile_offset;
        logic [15:0]        num_tiles;
        logic [31:0]        src_address;
        logic [31:0]        staging_size;
        logic signed [31:0] copy_bytes;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [7:0]  out_sheet;
        logic [15:0] out_tile;
    } t_out_item;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] count;
        logic [7:0]  sheet;
        logic [15:0] tile_base;
    } t_region;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STAGE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH,
        ST_OUT
    } t_state;

endpackage

@@ rtl/trrm_stage_cell.sv @@
// One staging registry cell: holds one entry and passes the search token on.
// Depends on trrm_pkg.
module trrm_stage_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_write,
    input  logic [7:0]  i_sheet,
    input  logic [31:0] i_base,
    input  logic [31:0] i_size,
    input  logic [15:0] i_first,
    input  logic        i_used,
    input  logic [31:0] i_src,
    input  logic        i_tok,
    output logic        o_tok,
    output logic        o_reg_hit,
    output logic        o_copy_hit,
    output logic        o_aligned,
    output logic [7:0]  o_sheet,
    output logic [15:0] o_tile
);
    import trrm_pkg::*;

    logic [7:0]  r_sheet;
    logic [31:0] r_base;
    logic [31:0] r_size;
    logic [15:0] r_first;
    logic        r_tok;
    logic [32:0] w_end;
    logic [31:0] w_off;

    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_sheet <= i_sheet;
            r_base  <= i_base;
            r_size  <= i_size;
            r_first <= i_first;
        end
    end

    // token walks the row one cell a cycle; a cell acts only while it holds it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_load ? 1'b0 : i_tok;
        end
    end

    assign w_end      = {1'b0, r_base} + {1'b0, r_size};
    assign w_off      = i_src - r_base;
    assign o_reg_hit  = r_tok && i_used && (r_sheet == i_sheet);
    assign o_copy_hit = r_tok && i_used && (i_src >= r_base) && ({1'b0, i_src} < w_end);
    assign o_aligned  = (w_off[4:0] == 5'd0);
    assign o_sheet    = r_sheet;
    assign o_tile     = r_first + w_off[20:5];
    assign o_tok      = r_tok;
endmodule

@@ rtl/tile_region_range_map.sv @@
// Tile region range map top level: control, staging cell row, region memory scan.
// Depends on trrm_pkg and trrm_stage_cell.
//
// Maps VRAM word addresses back to source tile sheets. The block keeps a region
// table in a memory with one write and one read port, and a staging registry
// as a row of cells. Items are taken one at a time. Clear is done on accept and
// record-sheet writes the memory in its finish state; register walks a token
// down the staging row, then writes a staging cell; record-copy walks the
// staging row, then, on a usable match, reads the region memory newest entry
// first, one entry per cycle, and writes the region entry; resolve reads
// every used region once. The single region memory read port sets the scan
// rate. Only resolve gives a result item, held in an output register until
// taken.
module tile_region_range_map #(
    parameter int unsigned REGION_DEPTH  = trrm_pkg::REGION_DEPTH_DEF,
    parameter int unsigned STAGING_DEPTH = trrm_pkg::STAGING_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  trrm_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output trrm_pkg::t_out_item o_item
);
    import trrm_pkg::*;

    localparam int unsigned RW = $clog2(REGION_DEPTH + 1);
    localparam int unsigned RA = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
    localparam int unsigned SW = $clog2(STAGING_DEPTH + 1);
    localparam int unsigned SA = (STAGING_DEPTH > 1) ? $clog2(STAGING_DEPTH) : 1;

    t_state    r_state, n_state;
    t_in_item  r_in;
    logic [RW-1:0] r_rused;
    logic [SW-1:0] r_sused;
    logic [RW-1:0] r_idx;        // entries still to read
    logic          r_rd_v;       // memory data valid this cycle
    logic [RA-1:0] r_rd_k;
    t_region   r_mem [REGION_DEPTH];
    t_region   r_rd;
    logic          r_found;
    logic [RA-1:0] r_best;
    logic [15:0]   r_bcount;
    logic [7:0]    r_bsheet;
    logic [15:0]   r_btile;
    logic [15:0]   r_baddr;
    logic          r_sfound;     // staging search done with a match
    logic          r_sok;        // match usable for copy
    logic [7:0]    r_csheet;
    logic [15:0]   r_ctile;
    logic [SA-1:0] r_shit;
    t_out_item r_out;
    logic      r_ov;

    // staging row
    logic [STAGING_DEPTH:0] w_tok;
    logic [STAGING_DEPTH-1:0] w_rh, w_ch, w_al, w_wr, w_used;
    logic [7:0]  w_sh [STAGING_DEPTH];
    logic [15:0] w_tl [STAGING_DEPTH];
    logic w_load, w_any_rh, w_any_ch;
    logic [SA-1:0] w_hidx;
    logic w_hal;
    logic [7:0] w_hsh;
    logic [15:0] w_htl;

    logic [15:0] w_count;
    logic [15:0] w_end;
    logic w_cov, w_match;
    logic w_copy_ok;

    assign w_load = (r_state == ST_IDLE) && i_valid;
    assign w_tok[0] = w_load && (i_item.operation == OP_REGISTER ||
                                 i_item.operation == OP_COPY);

    // a new item flushes any token left in the row; the first cell takes the new one
    for (genvar g = 0; g < STAGING_DEPTH; g++) begin : g_cell
        assign w_used[g] = (SW'(g) < r_sused);
        trrm_stage_cell u_cell (
            .i_clk, .i_rst_n,
            .i_load (w_load && (g != 0)),
            .i_write(w_wr[g]),
            .i_sheet(r_in.sheet),
            .i_base (r_in.src_address),
            .i_size (r_in.staging_size),
            .i_first(r_in.tile_offset),
            .i_used (w_used[g] && r_state == ST_STAGE && !r_sfound),
            .i_src  (r_in.src_address),
            .i_tok  (w_tok[g]),
            .o_tok  (w_tok[g+1]),
            .o_reg_hit (w_rh[g]),
            .o_copy_hit(w_ch[g]),
            .o_aligned (w_al[g]),
            .o_sheet(w_sh[g]),
            .o_tile (w_tl[g])
        );
    end

    // only the token holder can hit, so at most one bit is set
    always_comb begin
        w_hidx = '0; w_hal = 1'b0; w_hsh = '0; w_htl = '0;
        for (int i = 0; i < STAGING_DEPTH; i++) begin
            if (w_rh[i] || w_ch[i]) begin
                w_hidx = SA'(i); w_hal = w_al[i]; w_hsh = w_sh[i]; w_htl = w_tl[i];
            end
        end
    end
    assign w_any_rh = r_in.operation == OP_REGISTER && (|w_rh);
    assign w_any_ch = r_in.operation == OP_COPY && (|w_ch);

    always_comb begin
        w_wr = '0;
        if (r_state == ST_FINISH && r_in.operation == OP_REGISTER) begin
            if (r_sfound) begin
                w_wr[r_shit] = 1'b1;
            end else if (r_sused < SW'(STAGING_DEPTH)) begin
                w_wr[r_sused[SA-1:0]] = 1'b1;
            end
        end
    end

    assign w_count = r_in.copy_bytes[20:5];
    assign w_copy_ok = !r_in.copy_bytes[31] && (r_in.copy_bytes != 0) && (w_count != 0);
    assign w_end = r_rd.addr + {r_rd.count[11:0], 4'b0};
    assign w_cov = (r_in.vram_addr >= r_rd.addr) && (r_in.vram_addr < w_end);
    assign w_match = (r_rd.addr == r_in.vram_addr) && (r_rd.count == w_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.operation)
                        OP_REGISTER, OP_COPY: n_state = ST_STAGE;
                        OP_RESOLVE:           n_state = ST_SCAN;
                        OP_RECORD:            n_state = ST_FINISH;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end
            ST_STAGE: begin
                // a hit in the last cell waits for the match registers to load
                if ((w_tok[STAGING_DEPTH] && !(w_any_rh || w_any_ch)) || r_sfound) begin
                    n_state = (r_in.operation == OP_COPY) ?
                              ((r_sfound && r_sok && w_copy_ok) ? ST_SCAN : ST_IDLE)
                              : ST_FINISH;
                end
            end
            ST_SCAN:   n_state = (r_idx == '0) ? ST_WAIT : ST_SCAN;
            ST_WAIT:   n_state = r_rd_v ? ST_WAIT : ST_FINISH;
            ST_FINISH: n_state = (r_in.operation == OP_RESOLVE) ? ST_OUT : ST_IDLE;
            ST_OUT:    n_state = r_ov ? ST_OUT : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stall = (r_state != ST_IDLE);
    end
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rused <= '0;
            r_sused <= '0;
            r_ov    <= 1'b0;
            r_rd_v  <= 1'b0;
            r_found <= 1'b0;
            r_sfound <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            r_rd_v <= (r_state == ST_SCAN) && (r_idx != '0);
            if (r_state == ST_SCAN && r_idx != '0) r_idx <= r_idx - 1'b1;
            if (w_load) begin
                r_found  <= 1'b0;
                r_sfound <= 1'b0;
                r_idx    <= r_rused;
                if (i_item.operation == OP_CLEAR) r_rused <= '0;
            end
            if (r_state == ST_STAGE && (w_any_rh || w_any_ch)) r_sfound <= 1'b1;
            if (r_state == ST_STAGE && n_state == ST_SCAN) r_idx <= r_rused;
            // scan: newest first, strict compare keeps the newer on ties
            if (r_rd_v && !r_found) begin
                if (r_in.operation == OP_RESOLVE && w_cov) begin
                    r_found <= 1'b1; r_bcount <= r_rd.count;
                end else if (r_in.operation == OP_COPY && w_match) begin
                    r_found <= 1'b1;
                end
            end else if (r_rd_v && r_in.operation == OP_RESOLVE && w_cov &&
                         r_rd.count < r_bcount) begin
                r_bcount <= r_rd.count;
            end
            if (r_state == ST_FINISH) begin
                if (r_in.operation == OP_REGISTER && !r_sfound &&
                    r_sused < SW'(STAGING_DEPTH)) r_sused <= r_sused + 1'b1;
                if (r_in.operation == OP_RECORD && r_in.sheet != UNMAPPED_SHEET &&
                    r_in.num_tiles != 0 && r_rused < RW'(REGION_DEPTH))
                    r_rused <= r_rused + 1'b1;
                if (r_in.operation == OP_COPY && !r_found && r_rused < RW'(REGION_DEPTH))
                    r_rused <= r_rused + 1'b1;
                if (r_in.operation == OP_RESOLVE) r_ov <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_load) r_in <= i_item;
        r_rd_k <= r_idx[RA-1:0] - 1'b1;
        if (r_state == ST_STAGE && (w_any_rh || w_any_ch) && !r_sfound) begin
            r_shit   <= w_hidx;
            r_sok    <= w_hal;
            r_csheet <= w_hsh;
            r_ctile  <= w_htl;
        end
        if (r_rd_v && ((!r_found && r_in.operation == OP_COPY && w_match) ||
            (r_in.operation == OP_RESOLVE && w_cov &&
             (!r_found || r_rd.count < r_bcount)))) begin
            r_best   <= r_rd_k;
            r_bsheet <= r_rd.sheet;
            r_btile  <= r_rd.tile_base;
            r_baddr  <= r_rd.addr;
        end
        if (r_state == ST_FINISH && r_in.operation == OP_RESOLVE) begin
            r_out.hit       <= r_found && r_bsheet != UNMAPPED_SHEET;
            r_out.out_sheet <= (r_found && r_bsheet != UNMAPPED_SHEET) ? r_bsheet : 8'd0;
            r_out.out_tile  <= (r_found && r_bsheet != UNMAPPED_SHEET) ?
                               r_btile + 16'((r_in.vram_addr - r_baddr) >> 4) : 16'd0;
        end
    end

    // region memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH) begin
            if (r_in.operation == OP_RECORD && r_in.sheet != UNMAPPED_SHEET &&
                r_in.num_tiles != 0 && r_rused < RW'(REGION_DEPTH)) begin
                r_mem[r_rused[RA-1:0]] <= '{r_in.vram_addr, r_in.num_tiles,
                                            r_in.sheet, r_in.tile_offset};
            end else if (r_in.operation == OP_COPY && r_found) begin
                r_mem[r_best] <= '{r_baddr, w_count, r_csheet, r_ctile};
            end else if (r_in.operation == OP_COPY && r_rused < RW'(REGION_DEPTH)) begin
                r_mem[r_rused[RA-1:0]] <= '{r_in.vram_addr, w_count, r_csheet, r_ctile};
            end
        end
        if (r_state == ST_SCAN && r_idx != '0) r_rd <= r_mem[r_idx[RA-1:0] - 1'b1];
    end
endmodule

@@ tb/sv/tb_tile_region_range_map.sv @@
// Testbench for tile_region_range_map: directed and random items, scoreboard
// against an in-bench predictor of the region and staging tables.
// Depends on trrm_pkg and the tile_region_range_map RTL.
`timescale 1ns / 1ps

module tb_tile_region_range_map;
    import trrm_pkg::*;

    localparam int REGIONS  = REGION_DEPTH_DEF;
    localparam int STAGINGS = STAGING_DEPTH_DEF;

    logic      clk;
    logic      rst_n;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    tile_region_range_map dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_item  (out_item)
    );

    // Predictor copy of the block state
    t_region     map_regions [REGIONS];
    int          map_used;
    logic [7:0]  stg_sheet [STAGINGS];
    logic [31:0] stg_base  [STAGINGS];
    logic [31:0] stg_size  [STAGINGS];
    logic [15:0] stg_first [STAGINGS];
    int          stg_used;

    t_in_item  pending_items[$];
    t_out_item lookup_results[$];
    int        fail_count = 0;
    int        gap_left;
    int        stall_left;
    bit        stim_done = 1'b0;

    function automatic void add_region(logic [15:0] a, logic [15:0] c,
                                       logic [7:0] s, logic [15:0] t);
        if (map_used < REGIONS) begin
            map_regions[map_used] = '{addr: a, count: c, sheet: s, tile_base: t};
            map_used++;
        end
    endfunction

    // Apply one accepted item to the predictor; push a lookup result if any.
    function automatic void predict_item(t_in_item it);
        bit          found;
        int          best;
        logic [15:0] best_cnt;
        logic [15:0] region_end;
        logic [32:0] stg_end;
        logic [31:0] off;
        logic [7:0]  s;
        logic [15:0] t;
        logic [15:0] cnt;
        logic [15:0] idx;
        t_out_item   r;
        found = 0;
        best = 0;
        best_cnt = '0;
        s = '0;
        t = '0;
        case (it.operation)
            OP_CLEAR: map_used = 0;
            OP_REGISTER: begin
                for (int i = 0; i < stg_used; i++) begin
                    if (!found && stg_sheet[i] == it.sheet) begin
                        stg_base[i]  = it.src_address;
                        stg_size[i]  = it.staging_size;
                        stg_first[i] = it.tile_offset;
                        found = 1;
                    end
                end
                if (!found && stg_used < STAGINGS) begin
                    stg_sheet[stg_used] = it.sheet;
                    stg_base[stg_used]  = it.src_address;
                    stg_size[stg_used]  = it.staging_size;
                    stg_first[stg_used] = it.tile_offset;
                    stg_used++;
                end
            end
            OP_RECORD: begin
                if (it.sheet != UNMAPPED_SHEET && it.num_tiles != 0)
                    add_region(it.vram_addr, it.num_tiles, it.sheet, it.tile_offset);
            end
            OP_COPY: begin
                if (it.copy_bytes <= 0) return;
                for (int i = 0; i < stg_used; i++) begin
                    stg_end = {1'b0, stg_base[i]} + {1'b0, stg_size[i]};
                    if (it.src_address >= stg_base[i] && {1'b0, it.src_address} < stg_end) begin
                        off = it.src_address - stg_base[i];
                        if (off[4:0] != 0) return;
                        found = 1;
                        s = stg_sheet[i];
                        t = stg_first[i] + off[20:5];
                        break;
                    end
                end
                if (!found) return;
                cnt = it.copy_bytes[20:5];
                if (cnt == 0) return;
                for (int i = map_used - 1; i >= 0; i--) begin
                    if (map_regions[i].addr == it.vram_addr && map_regions[i].count == cnt) begin
                        map_regions[i].sheet = s;
                        map_regions[i].tile_base = t;
                        return;
                    end
                end
                add_region(it.vram_addr, cnt, s, t);
            end
            OP_RESOLVE: begin
                // newest first, strictly smaller count wins, so ties go to newest
                for (int i = map_used - 1; i >= 0; i--) begin
                    region_end = map_regions[i].addr + {map_regions[i].count[11:0], 4'b0};
                    if (it.vram_addr >= map_regions[i].addr && it.vram_addr < region_end) begin
                        if (!found || map_regions[i].count < best_cnt) begin
                            found = 1;
                            best = i;
                            best_cnt = map_regions[i].count;
                        end
                    end
                end
                r = '0;
                if (found && map_regions[best].sheet != UNMAPPED_SHEET) begin
                    idx = (it.vram_addr - map_regions[best].addr) >> 4;
                    r.hit = 1'b1;
                    r.out_sheet = map_regions[best].sheet;
                    r.out_tile = map_regions[best].tile_base + idx;
                end
                lookup_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item blank_item(t_op op);
        t_in_item it;
        it = '0;
        it.operation = op;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.operation    = 3'($urandom_range(7, 0));
        it.vram_addr    = 16'($urandom);
        it.sheet        = 8'($urandom);
        it.tile_offset  = 16'($urandom);
        it.num_tiles    = 16'($urandom);
        it.src_address  = $urandom;
        it.staging_size = $urandom;
        it.copy_bytes   = $urandom;
        return it;
    endfunction

    // Well-formed item with random content around a small address pool so that
    // records, copies and lookups actually overlap.
    function automatic t_in_item shaped_item();
        t_in_item it;
        int       pick;
        it = rand_item();
        pick = $urandom_range(99, 0);
        it.vram_addr = 16'($urandom_range(1023, 0));
        if (pick < 2) begin
            it.operation = OP_CLEAR;
        end else if (pick < 8) begin
            it.operation = OP_REGISTER;
            it.sheet = ($urandom_range(7, 0) == 0) ? UNMAPPED_SHEET
                                                   : 8'($urandom_range(11, 0));
            it.src_address = 32'($urandom_range(15, 0)) << 12;
            it.staging_size = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(8192, 0);
        end else if (pick < 30) begin
            it.operation = OP_RECORD;
            it.sheet = ($urandom_range(9, 0) == 0) ? UNMAPPED_SHEET
                                                   : 8'($urandom_range(20, 0));
            it.num_tiles = ($urandom_range(9, 0) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(40, 0));
        end else if (pick < 55) begin
            it.operation = OP_COPY;
            it.src_address = (32'($urandom_range(15, 0)) << 12) +
                             (($urandom_range(5, 0) == 0) ? $urandom_range(4095, 0)
                                                          : 32 * $urandom_range(127, 0));
            it.copy_bytes = ($urandom_range(9, 0) == 0) ? $urandom
                                                        : 32 * $urandom_range(40, 0);
            it.vram_addr = 16'(16 * $urandom_range(63, 0));
        end else if (pick < 95) begin
            it.operation = OP_RESOLVE;
        end
        return it;
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Stimulus
    initial begin
        t_in_item it;
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: lookup in empty table, field extremes
        pending_items.push_back(blank_item(OP_RESOLVE));
        it = blank_item(OP_RECORD);
        it.vram_addr = 16'h0100; it.sheet = 8'd3; it.tile_offset = 16'hFFFE;
        it.num_tiles = 16'd4;
        pending_items.push_back(it);
        it.operation = OP_RESOLVE; it.vram_addr = 16'h0130;
        pending_items.push_back(it);
        it = blank_item(OP_RECORD);                      // unmapped sheet is ignored
        it.sheet = UNMAPPED_SHEET; it.num_tiles = 16'd5;
        pending_items.push_back(it);
        it.sheet = 8'd4; it.num_tiles = '0;              // zero count is ignored
        pending_items.push_back(it);
        it = blank_item(OP_RECORD);                      // region whose end wraps
        it.vram_addr = 16'hFFF0; it.sheet = 8'd9; it.num_tiles = 16'hFFFF;
        pending_items.push_back(it);
        it.operation = OP_RESOLVE;
        pending_items.push_back(it);
        it = blank_item(OP_REGISTER);                    // staging bound past 32 bits
        it.sheet = 8'd1; it.src_address = 32'hFFFF_FF00; it.staging_size = 32'hFFFF_FFFF;
        it.tile_offset = 16'hFFFF;
        pending_items.push_back(it);
        it = blank_item(OP_REGISTER);
        it.sheet = UNMAPPED_SHEET; it.src_address = 32'h1000; it.staging_size = 32'h400;
        pending_items.push_back(it);
        it = blank_item(OP_COPY);                        // copy at top of address space
        it.vram_addr = 16'h0100; it.src_address = 32'hFFFF_FFE0; it.copy_bytes = 128;
        pending_items.push_back(it);
        it.src_address = 32'h1001;                       // misaligned offset
        pending_items.push_back(it);
        it.src_address = 32'h1020; it.copy_bytes = -32'sd64;   // negative byte count
        pending_items.push_back(it);
        it.copy_bytes = 32'sh7FFF_FFFF;                  // huge count wraps tiles
        pending_items.push_back(it);
        it.copy_bytes = 31;                              // under one tile
        pending_items.push_back(it);
        it.src_address = 32'h1020; it.copy_bytes = 64;   // unmapped marker region
        it.vram_addr = 16'h0200;
        pending_items.push_back(it);
        it.src_address = 32'h5000;                       // no staging entry
        pending_items.push_back(it);
        it = blank_item(OP_RESOLVE); it.vram_addr = 16'h0210;
        pending_items.push_back(it);
        it.vram_addr = 16'hFFFF;
        pending_items.push_back(it);
        it = blank_item(OP_REGISTER); it.sheet = 8'd1;   // update in place
        it.src_address = 32'h2000; it.staging_size = 32'h100;
        pending_items.push_back(it);
        pending_items.push_back(blank_item(t_op'(3'd5)));
        pending_items.push_back(blank_item(t_op'(3'd7)));
        pending_items.push_back(blank_item(OP_CLEAR));
        it = blank_item(OP_RESOLVE); it.vram_addr = 16'h0130;
        pending_items.push_back(it);

        // random: mostly shaped, some raw noise; periodic fills to reach table full
        for (int n = 0; n < 1150; n++) begin
            if (n % 500 == 250) begin
                for (int k = 0; k < 140; k++) begin
                    it = blank_item(OP_RECORD);
                    it.vram_addr = 16'($urandom_range(1023, 0));
                    it.sheet = 8'($urandom_range(254, 0));
                    it.tile_offset = 16'($urandom);
                    it.num_tiles = 16'($urandom_range(8, 1));
                    pending_items.push_back(it);
                end
            end
            pending_items.push_back(($urandom_range(9, 0) == 0) ? rand_item() : shaped_item());
        end
        stim_done = 1;
    end

    // Driver: one item per handshake, random gap before each
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_item  <= '0;
            gap_left <= 0;
        end else if (in_valid && !in_stall) begin
            predict_item(in_item);
            in_valid <= 0;
            gap_left <= $urandom_range(3, 0) == 0 ? 0 : $urandom_range(9, 0);
        end else if (!in_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1;
            end
        end
    end

    // Monitor with random output stall
    always @(posedge clk) begin
        t_out_item exp_r;
        if (!rst_n) begin
            out_stall  <= 0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (lookup_results.size() == 0) begin
                    $error("unexpected result item %h", out_item);
                    fail_count++;
                end else begin
                    exp_r = lookup_results.pop_front();
                    if (out_item.hit !== exp_r.hit) begin
                        $error("hit: expected %h actual %h", exp_r.hit, out_item.hit);
                        fail_count++;
                    end
                    if (out_item.out_sheet !== exp_r.out_sheet) begin
                        $error("out_sheet: expected %h actual %h",
                               exp_r.out_sheet, out_item.out_sheet);
                        fail_count++;
                    end
                    if (out_item.out_tile !== exp_r.out_tile) begin
                        $error("out_tile: expected %h actual %h",
                               exp_r.out_tile, out_item.out_tile);
                        fail_count++;
                    end
                end
                stall_left <= $urandom_range(3, 0) == 0 ? 0 : $urandom_range(9, 0);
                out_stall  <= 1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1;
            end else begin
                out_stall <= 0;
            end
        end
    end

    // End of run: everything sent, nothing expected, then drain latency
    initial begin
        wait (rst_n === 1'b1);
        wait (stim_done && pending_items.size() == 0);
        @(posedge clk);
        while (in_valid || lookup_results.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && lookup_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: ~1450 items, each with random gaps and output stalls
    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
